>>> hdl/sha1bsh_pkg.sv
`timescale 1ns / 1ps
// Package for the SHA-1 byte stream hasher: operation codes, hash constants,
// controller state type and the command and status structs between the modules.
// Depends on nothing.
package sha1bsh_pkg;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam int NUM_WORDS = 5;
   localparam int NUM_ROUNDS = 80;
   localparam int BLOCK_WORDS = 16;

   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [5:0] LAST_BYTE = 6'd63;
   localparam logic [5:0] LENGTH_START = 6'd56;
   localparam logic [2:0] LAST_INDEX = 3'd4;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] IV [NUM_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      BSEL_DATA,
      BSEL_MARK,
      BSEL_ZERO,
      BSEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic         latch_len;
      logic         load_work;
      logic         round_step;
      logic         final_add;
      logic         blk_inc;
      logic         init;
      logic         out_step;
   } cmd_type;

   typedef struct packed {
      logic [5:0] byte_count;
      logic       round_last;
      logic       last_word;
   } stat_type;

endpackage

>>> hdl/sha1bsh_dpath.sv
`timescale 1ns / 1ps
// Datapath of the SHA-1 byte stream hasher: message window, round unit,
// chaining value, length and digest output registers. Depends on sha1bsh_pkg.
module sha1bsh_dpath
   import sha1bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [7:0]  data_byte,
   output logic [31:0] digest_word,
   output logic [2:0]  word_index,
   output logic        last_word
);

   logic [31:0] win_ff [BLOCK_WORDS];
   logic [31:0] win_in [BLOCK_WORDS];
   logic [31:0] h_ff [NUM_WORDS];
   logic [31:0] h_in [NUM_WORDS];
   logic [31:0] wk_ff [NUM_WORDS];
   logic [31:0] wk_in [NUM_WORDS];
   logic [6:0]  rnd_ff, rnd_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [54:0] blk_ff, blk_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  byte_val;
   logic [31:0] w_mix;
   logic [31:0] w_new;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;

   always_comb begin
      case (cmd.byte_sel)
         BSEL_DATA: byte_val = data_byte;
         BSEL_MARK: byte_val = PAD_MARK;
         BSEL_LEN:  byte_val = len_ff[63:56];
         default:   byte_val = 8'h00;
      endcase
   end

   assign w_mix = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign w_new = {w_mix[30:0], w_mix[31]};

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_val = (wk_ff[1] & wk_ff[2]) ^ (~wk_ff[1] & wk_ff[3]);
         k_val = K0;
      end else if (rnd_ff < 7'd40) begin
         f_val = wk_ff[1] ^ wk_ff[2] ^ wk_ff[3];
         k_val = K1;
      end else if (rnd_ff < 7'd60) begin
         f_val = (wk_ff[1] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[3]) ^ (wk_ff[2] & wk_ff[3]);
         k_val = K2;
      end else begin
         f_val = wk_ff[1] ^ wk_ff[2] ^ wk_ff[3];
         k_val = K3;
      end
   end

   assign t_val = {wk_ff[0][26:0], wk_ff[0][31:27]} + f_val + wk_ff[4] + k_val + win_ff[0];

   always_comb begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.shift_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i + 1][31:24]};
         end
         win_in[BLOCK_WORDS - 1] = {win_ff[BLOCK_WORDS - 1][23:0], byte_val};
      end else if (cmd.round_step) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[BLOCK_WORDS - 1] = w_new;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         wk_in[i] = wk_ff[i];
         h_in[i] = h_ff[i];
      end
      if (cmd.load_work) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            wk_in[i] = h_ff[i];
         end
      end else if (cmd.round_step) begin
         wk_in[0] = t_val;
         wk_in[1] = wk_ff[0];
         wk_in[2] = {wk_ff[1][1:0], wk_ff[1][31:2]};
         wk_in[3] = wk_ff[2];
         wk_in[4] = wk_ff[3];
      end
      if (cmd.init) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            h_in[i] = IV[i];
         end
      end else if (cmd.final_add) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            h_in[i] = h_ff[i] + wk_ff[i];
         end
      end
   end

   always_comb begin
      rnd_in = rnd_ff;
      if (cmd.load_work) begin
         rnd_in = '0;
      end else if (cmd.round_step && rnd_ff != LAST_ROUND) begin
         rnd_in = rnd_ff + 7'd1;
      end

      cnt_in = cnt_ff;
      if (cmd.init) begin
         cnt_in = '0;
      end else if (cmd.shift_en) begin
         cnt_in = cnt_ff + 6'd1;
      end

      blk_in = blk_ff;
      if (cmd.init) begin
         blk_in = '0;
      end else if (cmd.blk_inc) begin
         blk_in = blk_ff + 55'd1;
      end

      len_in = len_ff;
      if (cmd.latch_len) begin
         len_in = {blk_ff, cnt_ff, 3'b000};
      end else if (cmd.shift_en && cmd.byte_sel == BSEL_LEN) begin
         len_in = {len_ff[55:0], 8'h00};
      end

      idx_in = idx_ff;
      if (cmd.out_step) begin
         idx_in = (idx_ff == LAST_INDEX) ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         win_ff[i] <= win_in[i];
      end
      for (int i = 0; i < NUM_WORDS; i++) begin
         wk_ff[i] <= wk_in[i];
      end
      len_ff <= len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            h_ff[i] <= IV[i];
         end
         rnd_ff <= '0;
         cnt_ff <= '0;
         blk_ff <= '0;
         idx_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            h_ff[i] <= h_in[i];
         end
         rnd_ff <= rnd_in;
         cnt_ff <= cnt_in;
         blk_ff <= blk_in;
         idx_ff <= idx_in;
      end
   end

   assign digest_word = h_ff[idx_ff];
   assign word_index = idx_ff;
   assign last_word = (idx_ff == LAST_INDEX);

   assign stat.byte_count = cnt_ff;
   assign stat.round_last = (rnd_ff == LAST_ROUND);
   assign stat.last_word = (idx_ff == LAST_INDEX);

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_INDEX)
      else $error("digest word index out of range");

   a_round_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_work |=> rnd_ff == 7'd0)
      else $error("round counter not cleared at block start");

endmodule

>>> hdl/sha1bsh_ctrl.sv
`timescale 1ns / 1ps
// Controller of the SHA-1 byte stream hasher: sequences absorb, padding,
// compression rounds and digest output. Depends on sha1bsh_pkg.
module sha1bsh_ctrl
   import sha1bsh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_operation,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      ovf_ff, ovf_in;

   always_comb begin
      state_in = state_ff;
      fin_in = fin_ff;
      ovf_in = ovf_ff;
      cmd = '0;
      cmd.byte_sel = BSEL_ZERO;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.shift_en = 1'b1;
               if (req_operation == OP_FINISH) begin
                  cmd.byte_sel = BSEL_MARK;
                  cmd.latch_len = 1'b1;
                  fin_in = 1'b1;
                  ovf_in = (stat.byte_count >= LENGTH_START);
                  state_in = ST_PAD;
               end else begin
                  cmd.byte_sel = BSEL_DATA;
               end
               if (stat.byte_count == LAST_BYTE) begin
                  cmd.load_work = 1'b1;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_PAD: begin
            cmd.shift_en = 1'b1;
            if (stat.byte_count >= LENGTH_START && !ovf_ff) begin
               cmd.byte_sel = BSEL_LEN;
            end
            if (stat.byte_count == LAST_BYTE) begin
               cmd.load_work = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (stat.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.final_add = 1'b1;
            if (!fin_ff) begin
               cmd.blk_inc = 1'b1;
               state_in = ST_IDLE;
            end else if (ovf_ff) begin
               ovf_in = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.out_step = 1'b1;
               if (stat.last_word) begin
                  cmd.init = 1'b1;
                  fin_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
         ovf_ff <= ovf_in;
      end
   end

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && stat.round_last) |=> state_ff == ST_ADD)
      else $error("round sequence did not end in the final add");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !fin_ff && !ovf_ff)
      else $error("finish flags left set while idle");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while digest words are pending");

endmodule

>>> hdl/sha1_byte_stream_hasher.sv
`timescale 1ns / 1ps
// Top level of the SHA-1 byte stream hasher: joins controller and datapath.
// Depends on sha1bsh_pkg, sha1bsh_ctrl and sha1bsh_dpath.
//
// Usage: each item on the req channel either absorbs one message byte
// (operation 0) or finishes the message (operation 1). Both channels use
// valid and ready. The 64th byte of a block also starts the compression,
// which holds req_ready low through the 80 rounds in one shared round unit
// and the chaining-value add. A finish shifts the 0x80 mark, the zero fill
// and the length into the message window one byte per cycle until the block
// is full, and then compresses it. When 56 or more bytes were buffered, a
// second block of zero fill and the length follows and is compressed in the
// same way. The hasher then presents the five digest words on the rsp channel,
// word 0 first, with last_word set on word 4. No item is taken while words are
// pending; a stalled receiver simply holds the current word. After the last
// word is taken the hasher returns to the initial hash values and a new
// message can start. Reset loads the initial values and empties the buffer.
module sha1_byte_stream_hasher
   import sha1bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   cmd_type  cmd;
   stat_type stat;

   sha1bsh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   sha1bsh_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .data_byte   (req_data_byte),
      .digest_word (rsp_digest_word),
      .word_index  (rsp_word_index),
      .last_word   (rsp_last_word)
   );

endmodule
